// ===== hdl/rvq_pkg.sv =====
package rvq_pkg;

  localparam int MAX_CODEBOOKS = 16;
  localparam int ENTRIES       = 256;
  localparam int STAGES        = 3;
  localparam int TABLE_DEPTH   = MAX_CODEBOOKS * ENTRIES;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH   = 8;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = QUEUE_AW + 1;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // sideband carried along with an operation
  typedef struct packed {
    logic [31:0] extra;
    logic        last;
    logic [15:0] scale;
  } tag_t;

endpackage

// ===== hdl/rvq_ram.sv =====
module rvq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rvq_fadd.sv =====
module rvq_fadd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  rvq_pkg::tag_t tag_in,
  output logic          busy,
  output logic          out_v,
  output logic [31:0]   res,
  output rvq_pkg::tag_t tag_out
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) begin
        n = 5'(26 - i);
      end
    end
    return n;
  endfunction

  // stage 1: unpack, order, align, add
  logic        a_nan, b_nan, a_inf, b_inf, swap, eff_sub;
  logic [31:0] x, y;
  logic [7:0]  ex, ey, d;
  logic [23:0] mx, my;
  logic [26:0] ye, ys, yal;
  logic        st;
  logic [27:0] sum;

  always_comb begin
    a_nan = (&a[30:23]) & (|a[22:0]);
    b_nan = (&b[30:23]) & (|b[22:0]);
    a_inf = (&a[30:23]) & ~(|a[22:0]);
    b_inf = (&b[30:23]) & ~(|b[22:0]);
    swap  = b[30:0] > a[30:0];
    x     = swap ? b : a;
    y     = swap ? a : b;
    ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx    = {|x[30:23], x[22:0]};
    my    = {|y[30:23], y[22:0]};
    d     = ex - ey;
    ye    = {my, 3'b000};
    if (d >= 8'd27) begin
      ys = '0;
      st = |my;
    end else begin
      ys = ye >> d;
      st = |(ye & ~({27{1'b1}} << d));
    end
    yal     = {ys[26:1], ys[0] | st};
    eff_sub = x[31] ^ y[31];
    if (eff_sub) begin
      sum = {1'b0, mx, 3'b000} - {1'b0, yal};
    end else begin
      sum = {1'b0, mx, 3'b000} + {1'b0, yal};
    end
  end

  logic          s1_v_r;
  logic          s1_sign_r, s1_sub_r, s1_nan_r, s1_inf_r, s1_isgn_r;
  logic [7:0]    s1_exp_r;
  logic [27:0]   s1_sum_r;
  rvq_pkg::tag_t s1_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_sign_r <= x[31];
    s1_sub_r  <= eff_sub;
    s1_nan_r  <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    s1_inf_r  <= a_inf | b_inf;
    s1_isgn_r <= a_inf ? a[31] : b[31];
    s1_exp_r  <= ex;
    s1_sum_r  <= sum;
    s1_tag_r  <= tag_in;
  end

  // stage 2: normalize, round, pack
  logic [4:0]  lz, sh;
  logic [26:0] m;
  logic [8:0]  e9;
  logic        up;
  logic [30:0] packed_v;
  logic [31:0] r;

  always_comb begin
    lz = lzc27(s1_sum_r[26:0]);
    sh = 5'd0;
    if (s1_sum_r[27]) begin
      m  = {s1_sum_r[27:2], s1_sum_r[1] | s1_sum_r[0]};
      e9 = {1'b0, s1_exp_r} + 9'd1;
    end else begin
      if ({3'b000, lz} < s1_exp_r) begin
        sh = lz;
      end else begin
        sh = 5'(s1_exp_r - 8'd1);
      end
      m  = s1_sum_r[26:0] << sh;
      e9 = m[26] ? ({1'b0, s1_exp_r} - {4'b0000, sh}) : 9'd0;
    end
    up       = m[2] & (m[1] | m[0] | m[3]);
    packed_v = {e9[7:0], m[25:3]} + {30'd0, up};
    if (s1_nan_r) begin
      r = rvq_pkg::QNAN;
    end else if (s1_inf_r) begin
      r = {s1_isgn_r, 8'hFF, 23'd0};
    end else if (s1_sum_r == 28'd0) begin
      r = {s1_sub_r ? 1'b0 : s1_sign_r, 31'd0};
    end else if (e9 >= 9'd255) begin
      r = {s1_sign_r, 8'hFF, 23'd0};
    end else begin
      r = {s1_sign_r, packed_v};
    end
  end

  logic          out_v_r;
  logic [31:0]   res_r;
  rvq_pkg::tag_t tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= r;
    tag_r <= s1_tag_r;
  end

  assign busy    = s1_v_r;
  assign out_v   = out_v_r;
  assign res     = res_r;
  assign tag_out = tag_r;

endmodule

// ===== hdl/rvq_fmul.sv =====
module rvq_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_v,
  output logic [31:0] res
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // stage 1: unpack and multiply
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic signed [10:0] e;

  always_comb begin
    a_nan  = (&a[30:23]) & (|a[22:0]);
    b_nan  = (&b[30:23]) & (|b[22:0]);
    a_inf  = (&a[30:23]) & ~(|a[22:0]);
    b_inf  = (&b[30:23]) & ~(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {|a[30:23], a[22:0]};
    mb     = {|b[30:23], b[22:0]};
    e      = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
  end

  logic               s1_v_r, s1_sign_r, s1_nan_r, s1_inf_r;
  logic [47:0]        s1_p_r;
  logic signed [10:0] s1_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_sign_r <= a[31] ^ b[31];
    s1_nan_r  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    s1_inf_r  <= a_inf | b_inf;
    s1_p_r    <= ma * mb;
    s1_e_r    <= e;
  end

  // stage 2: leading zeros and shift amounts
  logic [5:0]         lz, shl, shr;
  logic signed [10:0] en, neg;

  always_comb begin
    lz  = lzc48(s1_p_r);
    en  = s1_e_r + 11'sd1 - $signed({5'b00000, lz});
    neg = -s1_e_r;
    shl = 6'd0;
    shr = 6'd0;
    if (en > 11'sd0) begin
      shl = lz;
    end else if (s1_e_r >= 11'sd0) begin
      shl = s1_e_r[5:0];
    end else if (neg > 11'sd63) begin
      shr = 6'd63;
    end else begin
      shr = neg[5:0];
    end
  end

  logic               s2_v_r, s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic [47:0]        s2_p_r;
  logic signed [10:0] s2_en_r;
  logic [5:0]         s2_shl_r, s2_shr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sign_r <= s1_sign_r;
    s2_nan_r  <= s1_nan_r;
    s2_inf_r  <= s1_inf_r;
    s2_zero_r <= (s1_p_r == 48'd0);
    s2_p_r    <= s1_p_r;
    s2_en_r   <= en;
    s2_shl_r  <= shl;
    s2_shr_r  <= shr;
  end

  // stage 3: shift, round, pack
  logic [47:0] m1, m2;
  logic        st, up;
  logic [7:0]  ef;
  logic [30:0] packed_v;
  logic [31:0] r;

  always_comb begin
    m1 = s2_p_r << s2_shl_r;
    if (s2_shr_r >= 6'd48) begin
      m2 = '0;
      st = |m1;
    end else begin
      m2 = m1 >> s2_shr_r;
      st = |(m1 & ~({48{1'b1}} << s2_shr_r));
    end
    ef       = (s2_en_r > 11'sd0) ? s2_en_r[7:0] : 8'd0;
    up       = m2[23] & ((|m2[22:0]) | st | m2[24]);
    packed_v = {ef, m2[46:24]} + {30'd0, up};
    if (s2_nan_r) begin
      r = rvq_pkg::QNAN;
    end else if (s2_inf_r) begin
      r = {s2_sign_r, 8'hFF, 23'd0};
    end else if (s2_zero_r) begin
      r = {s2_sign_r, 31'd0};
    end else if (s2_en_r >= 11'sd255) begin
      r = {s2_sign_r, 8'hFF, 23'd0};
    end else begin
      r = {s2_sign_r, packed_v};
    end
  end

  logic        out_v_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= r;
  end

  assign out_v = out_v_r;
  assign res   = res_r;

endmodule

// ===== hdl/residual_vq_row_decode.sv =====
// Three-stage additive VQ row decoder in fp32 (round to nearest even). Table writes may follow
// each other every cycle while in_ready is high. A row step reads all three stage tables at once
// (one synchronous RAM per stage), forms (s0+s1)+s2 in two adders, and queues the sum; the row
// accumulator takes a new queued step only when its accumulate adder holds no step in its first
// stage, so each step adds onto the sum of the one before. The row sum after its last step is
// multiplied by the fp16 scale; that last step enters the accumulator only when the multiplier
// and the output register are free. Up to 8 steps may be in flight.
module residual_vq_row_decode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_codebook,
  input  logic [1:0]  in_table_stage,
  input  logic [7:0]  in_table_entry,
  input  logic [31:0] in_table_value,
  input  logic [7:0]  in_index_stage0,
  input  logic [7:0]  in_index_stage1,
  input  logic [7:0]  in_index_stage2,
  input  logic [15:0] in_scale_half,
  input  logic        in_last_codebook,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_row_value
);

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  m;
    logic [3:0]  lz;
    logic [10:0] mn;
    logic [31:0] r;
    ex = h[14:10];
    m  = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        lz = 4'(9 - i);
      end
    end
    mn = {1'b0, m} << (lz + 4'd1);
    if (ex == 5'd0) begin
      if (m == 10'd0) begin
        r = {h[15], 31'd0};
      end else begin
        r = {h[15], 8'd112 - {4'd0, lz}, mn[9:0], 13'd0};
      end
    end else if (ex == 5'd31) begin
      r = (m != 10'd0) ? rvq_pkg::QNAN : {h[15], 8'hFF, 23'd0};
    end else begin
      r = {h[15], {3'b000, ex} + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  logic in_acc, is_step, step_acc, cb_ok;
  assign in_acc   = in_valid & in_ready;
  assign is_step  = (rvq_pkg::cmd_t'(in_command) == rvq_pkg::CMD_STEP);
  assign step_acc = in_acc & is_step;
  assign cb_ok    = (int'(in_codebook) < rvq_pkg::MAX_CODEBOOKS);

  // table memories, one per stage
  logic [7:0]                  idx   [rvq_pkg::STAGES];
  logic [rvq_pkg::ADDR_W-1:0]  raddr [rvq_pkg::STAGES];
  logic [31:0]                 q     [rvq_pkg::STAGES];
  logic                        we    [rvq_pkg::STAGES];
  logic [rvq_pkg::ADDR_W-1:0]  waddr;
  logic                        wr_ok;

  assign idx[0] = in_index_stage0;
  assign idx[1] = in_index_stage1;
  assign idx[2] = in_index_stage2;
  assign waddr  = rvq_pkg::ADDR_W'(int'(in_codebook) * rvq_pkg::ENTRIES
                                   + int'(in_table_entry));
  assign wr_ok  = in_acc & ~is_step & cb_ok & (int'(in_table_entry) < rvq_pkg::ENTRIES);

  logic f1_v_r, f1_last_r;
  logic [15:0] f1_scale_r;
  logic [rvq_pkg::STAGES-1:0] f1_zero_r;

  for (genvar g = 0; g < rvq_pkg::STAGES; g++) begin : g_stage
    assign raddr[g] = rvq_pkg::ADDR_W'(int'(in_codebook) * rvq_pkg::ENTRIES + int'(idx[g]));
    assign we[g]    = wr_ok & (in_table_stage == 2'(g));

    rvq_ram #(
      .WIDTH(32),
      .DEPTH(rvq_pkg::TABLE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we[g]),
      .waddr(waddr),
      .wdata(in_table_value),
      .raddr(raddr[g]),
      .rdata(q[g])
    );

    always_ff @(posedge clk) begin
      f1_zero_r[g] <= ~(cb_ok & (int'(idx[g]) < rvq_pkg::ENTRIES));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= step_acc;
    end
  end

  always_ff @(posedge clk) begin
    f1_last_r  <= in_last_codebook;
    f1_scale_r <= in_scale_half;
  end

  logic [31:0] s0, s1, s2;
  assign s0 = f1_zero_r[0] ? 32'd0 : q[0];
  assign s1 = f1_zero_r[1] ? 32'd0 : q[1];
  assign s2 = f1_zero_r[2] ? 32'd0 : q[2];

  // stage sum (s0 + s1) + s2
  rvq_pkg::tag_t a_tag_in, a_tag, b_tag;
  logic          a_v, b_v, a_busy, b_busy;
  logic [31:0]   a_res, b_res;

  assign a_tag_in = '{extra: s2, last: f1_last_r, scale: f1_scale_r};

  rvq_fadd u_add_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (f1_v_r),
    .a      (s0),
    .b      (s1),
    .tag_in (a_tag_in),
    .busy   (a_busy),
    .out_v  (a_v),
    .res    (a_res),
    .tag_out(a_tag)
  );

  rvq_fadd u_add_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (a_v),
    .a      (a_res),
    .b      (a_tag.extra),
    .tag_in (a_tag),
    .busy   (b_busy),
    .out_v  (b_v),
    .res    (b_res),
    .tag_out(b_tag)
  );

  // step queue
  rvq_pkg::tag_t                queue_r [rvq_pkg::QUEUE_DEPTH];
  logic [rvq_pkg::QUEUE_AW-1:0] wptr_r, rptr_r;
  logic [rvq_pkg::CNT_W-1:0]    qcnt_r, qcnt_nxt, credit_r, credit_nxt;
  rvq_pkg::tag_t                head;
  logic                         pop;

  assign head     = queue_r[rptr_r];
  assign in_ready = (credit_r < rvq_pkg::CNT_W'(rvq_pkg::QUEUE_DEPTH));

  always_comb begin
    qcnt_nxt   = qcnt_r + rvq_pkg::CNT_W'(b_v) - rvq_pkg::CNT_W'(pop);
    credit_nxt = credit_r + rvq_pkg::CNT_W'(step_acc) - rvq_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      qcnt_r   <= '0;
      credit_r <= '0;
    end else begin
      if (b_v) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      qcnt_r   <= qcnt_nxt;
      credit_r <= credit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_v) begin
      queue_r[wptr_r] <= '{extra: b_res, last: b_tag.last, scale: b_tag.scale};
    end
  end

  // row accumulator
  rvq_pkg::tag_t acc_tag;
  logic          acc_v, acc_busy, last_busy_r, last_busy_nxt;
  logic [31:0]   acc_res, acc_r, acc_nxt, acc_src;
  logic          mul_v;
  logic [31:0]   mul_res;

  always_comb begin
    acc_src = acc_r;
    if (acc_v) begin
      acc_src = acc_tag.last ? 32'd0 : acc_res;
    end
    acc_nxt = acc_src;
    pop = (qcnt_r != '0) & ~acc_busy & (~head.last | (~last_busy_r & ~out_valid));
    last_busy_nxt = last_busy_r;
    if (mul_v) begin
      last_busy_nxt = 1'b0;
    end
    if (pop & head.last) begin
      last_busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 32'd0;
      last_busy_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      last_busy_r <= last_busy_nxt;
    end
  end

  rvq_fadd u_add_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (pop),
    .a      (acc_src),
    .b      (head.extra),
    .tag_in (head),
    .busy   (acc_busy),
    .out_v  (acc_v),
    .res    (acc_res),
    .tag_out(acc_tag)
  );

  rvq_fmul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .in_v (acc_v & acc_tag.last),
    .a    (acc_res),
    .b    (half_to_single(acc_tag.scale)),
    .out_v(mul_v),
    .res  (mul_res)
  );

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_row_value_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (mul_v) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_v) begin
      out_row_value_r <= mul_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_value = out_row_value_r;

endmodule
